// ===== sv/lsae_pkg.sv =====
// Package: types, constants and codes for the LED string animation engine.
package lsae_pkg;

  localparam int LedCount = 16;
  localparam int IdxW = $clog2(LedCount);
  localparam int CntW = $clog2(LedCount + 1);
  localparam int PixW = 24;

  localparam logic [15:0] DefaultPeriod = 16'd100;
  localparam logic [15:0] ResetRandFreq = 16'd512;
  localparam logic [7:0]  ResetThrobStep = 8'd4;
  localparam logic [7:0]  PresetThrobStep = 8'd2;
  localparam logic [7:0]  FireGreen = 8'd170;
  localparam logic [7:0]  FireRed = 8'd175;
  localparam logic [7:0]  RssiOffset = 8'd90;
  localparam logic [7:0]  RssiScale = 8'd9;

  typedef enum logic [2:0] {
    CMD_ANIM   = 3'd0,
    CMD_ACCEL  = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_APPLY  = 3'd3,
    CMD_PRESET = 3'd4,
    CMD_RSSI   = 3'd5,
    CMD_RSV6   = 3'd6,
    CMD_RSV7   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    M_STATIC  = 3'd0,
    M_FLASH   = 3'd1,
    M_ROTATE  = 3'd2,
    M_THROB   = 3'd3,
    M_RANDOM  = 3'd4,
    M_FIRE    = 3'd5,
    M_ORBIT   = 3'd6,
    M_ONESHOT = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    REG_MIN_PERIOD = 2'd0,
    REG_MAX_STEP   = 2'd1,
    REG_PRE_BLUE   = 2'd2,
    REG_PRE_PERIOD = 2'd3
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_ANIM,
    ST_DRAIN
  } state_t;

endpackage

// ===== sv/lsae_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
module lsae_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== sv/led_string_animation_engine_top.sv =====
// Top level of the LED string animation engine.
// One item at a time. An animation tick gives LedCount results on consecutive cycles,
// the first going through the lag register to the output registers; the last appears
// as busy drops. The frame walk through the frame memory sets when the next item can be
// accepted. Apply and preset walk the frame the same way; other commands leave the
// engine idle.
// After reset a clearing pass zeroes both memories while busy is high.
// Results carry out_valid for one cycle and cannot be stalled.
module led_string_animation_engine_top
  import lsae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_led_index,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_blue_in,
  input  logic [2:0]  in_mode_sel,
  input  logic [15:0] in_mode_arg,
  input  logic [15:0] in_period_ms,
  input  logic signed [7:0] in_rssi_dbm,
  input  logic [14:0] in_random_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [3:0]  out_pixel_index,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_blue_out,
  output logic        out_frame_last,
  output logic [15:0] out_anim_period
);

  state_t state_r, state_nxt;
  logic [15:0] min_period_r, pre_period_r;
  logic [7:0]  max_step_r, pre_blue_r;
  mode_t       mode_r;
  logic [7:0]  step_r, avg_r;
  logic        fading_r, accel_r, flash_r, pulse_r, clear_r, changed_r, rnd_ok_r;
  logic [15:0] rfreq_r, period_r, base_r;
  logic [IdxW-1:0] idx_r;
  logic [CntW-1:0] cnt_r;
  logic        frame_we, pat_we;
  logic [IdxW-1:0] frame_wa, pat_wa, rd_a;
  logic [PixW-1:0] frame_wd, pat_wd, frame_rd, pat_rd, first_r, new_pix;
  logic        dec_change;
  logic        fill_pat, fill_on_r;
  logic [IdxW-1:0] lag_r;
  logic        lag_v_r, lag_last_r;
  logic [7:0]  sample;
  logic [15:0] base_dec;
  logic        acc_go;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != ST_IDLE) || clear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= 16'd50;
      max_step_r <= 8'd5;
      pre_blue_r <= 8'd196;
      pre_period_r <= 16'd125;
    end else if (cfg_valid) begin
      unique case (reg_t'(cfg_index))
        REG_MIN_PERIOD: min_period_r <= cfg_data;
        REG_MAX_STEP:   max_step_r <= cfg_data[7:0];
        REG_PRE_BLUE:   pre_blue_r <= cfg_data[7:0];
        REG_PRE_PERIOD: pre_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lsae_ram #(.Width(PixW), .Depth(LedCount)) u_frame (
    .clk(clk), .we(frame_we), .waddr(frame_wa), .wdata(frame_wd),
    .raddr(rd_a), .rdata(frame_rd)
  );
  lsae_ram #(.Width(PixW), .Depth(LedCount)) u_pat (
    .clk(clk), .we(pat_we), .waddr(pat_wa), .wdata(pat_wd),
    .raddr(rd_a), .rdata(pat_rd)
  );

  function automatic logic [7:0] throb_ch(input logic [7:0] v, input logic [7:0] t,
                                          input logic [7:0] s, input logic f,
                                          output logic ch);
    logic [8:0] sum;
    begin
      sum = {1'b0, v} + {1'b0, s};
      ch = 1'b0;
      if (f) begin
        if (v >= s) begin
          ch = 1'b1;
          throb_ch = v - s;
        end else begin
          throb_ch = 8'd0;
        end
      end else if ({1'b0, t} > sum) begin
        ch = 1'b1;
        throb_ch = sum[7:0];
      end else begin
        throb_ch = t;
      end
    end
  endfunction

  // read address runs one LED ahead of the write (lag) address, two in rotate mode; park on LED 0 between walks
  assign rd_a = (state_r == ST_IDLE || state_r == ST_DRAIN) ? '0 : IdxW'(idx_r);

  always_comb begin
    logic c0, c1, c2;
    new_pix = frame_rd;
    c0 = 1'b0; c1 = 1'b0; c2 = 1'b0;
    if (fill_on_r) begin
      new_pix = fill_pat ? {16'd0, pre_blue_r} : pat_rd;
    end else begin
      unique case (mode_r)
        M_FLASH:   new_pix = flash_r ? pat_rd : '0;
        M_ROTATE:  new_pix = lag_last_r ? first_r : frame_rd;
        M_THROB: begin
          new_pix[23:16] = throb_ch(frame_rd[23:16], pat_rd[23:16], step_r, fading_r, c0);
          new_pix[15:8]  = throb_ch(frame_rd[15:8], pat_rd[15:8], step_r, fading_r, c1);
          new_pix[7:0]   = throb_ch(frame_rd[7:0], pat_rd[7:0], step_r, fading_r, c2);
        end
        M_RANDOM:  new_pix = rnd_ok_r ? pat_rd : '0;
        M_FIRE:    new_pix = {FireGreen, FireRed, 8'd0};
        M_ORBIT:   new_pix = {8'd0, avg_r, 8'd255 - avg_r};
        M_ONESHOT: new_pix = pulse_r ? '0 : frame_rd;
        default:   new_pix = frame_rd;
      endcase
    end
    dec_change = c0 | c1 | c2;
  end

  assign fill_pat = (mode_r == M_THROB) && accel_r && fill_on_r && changed_r;

  // rotate reads one ahead: address idx+1 feeds LED idx
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start && !clear_r) begin
        unique case (cmd_t'(in_cmd))
          CMD_ANIM: state_nxt = ST_ANIM;
          CMD_APPLY, CMD_PRESET: state_nxt = ST_FILL;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_FILL, ST_ANIM: if (cnt_r == CntW'(LedCount)) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    frame_we = 1'b0;
    frame_wa = lag_r;
    frame_wd = new_pix;
    pat_we = 1'b0;
    pat_wa = in_led_index[IdxW-1:0];
    pat_wd = {in_green_in, in_red_in, in_blue_in};
    if (clear_r) begin
      frame_we = 1'b1; pat_we = 1'b1;
      frame_wa = idx_r; pat_wa = idx_r;
      frame_wd = '0; pat_wd = '0;
    end else if (lag_v_r) begin
      frame_we = 1'b1;
      pat_we = fill_pat;
      pat_wa = lag_r;
      pat_wd = {16'd0, pre_blue_r};
    end else if (state_r == ST_IDLE && start && in_cmd == CMD_WRITE
                 && 32'(in_led_index) < LedCount) begin
      pat_we = 1'b1;
    end
  end

  assign sample = (in_rssi_dbm + RssiOffset) * RssiScale;
  assign base_dec = base_r - 16'd1;
  assign acc_go = (mode_r == M_THROB) && accel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      clear_r <= 1'b1;
      idx_r <= '0; cnt_r <= '0;
      lag_v_r <= 1'b0; lag_last_r <= 1'b0; lag_r <= '0;
      fill_on_r <= 1'b0; out_valid <= 1'b0;
      mode_r <= M_STATIC; step_r <= ResetThrobStep;
      fading_r <= 1'b0; accel_r <= 1'b0; rfreq_r <= ResetRandFreq;
      flash_r <= 1'b0; pulse_r <= 1'b0; period_r <= DefaultPeriod;
      base_r <= '0; avg_r <= '0; changed_r <= 1'b0; rnd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      if (clear_r) begin
        idx_r <= idx_r + 1'b1;
        if (32'(idx_r) == LedCount - 1) begin
          clear_r <= 1'b0; idx_r <= '0;
        end
      end else begin
        unique case (state_r)
          ST_IDLE: begin
            lag_v_r <= 1'b0;
            cnt_r <= CntW'(1);
            idx_r <= (mode_r == M_ROTATE) ? IdxW'(1) : '0;
            lag_r <= '0;
            changed_r <= 1'b0;
            if (start) begin
              unique case (cmd_t'(in_cmd))
                CMD_ANIM: begin
                  fill_on_r <= 1'b0;
                  rnd_ok_r <= {1'b0, in_random_value} <= rfreq_r;
                end
                CMD_ACCEL: if (acc_go) begin
                  if (base_r > min_period_r) begin
                    base_r <= (base_dec < min_period_r) ? min_period_r : base_dec;
                    period_r <= (base_dec < min_period_r) ? min_period_r : base_dec;
                  end else if (step_r < max_step_r) begin
                    step_r <= step_r + 8'd1;
                  end
                end
                CMD_APPLY: begin
                  fill_on_r <= 1'b1;
                  idx_r <= '0;
                  mode_r <= mode_t'(in_mode_sel);
                  if (in_mode_sel == M_RANDOM) rfreq_r <= in_mode_arg;
                  if (in_mode_sel == M_THROB) begin
                    step_r <= in_mode_arg[7:0]; fading_r <= 1'b1; accel_r <= 1'b0;
                  end
                  if (in_mode_sel == M_ONESHOT) pulse_r <= 1'b1;
                  period_r <= in_period_ms;
                  base_r <= in_period_ms;
                end
                CMD_PRESET: begin
                  fill_on_r <= 1'b1;
                  idx_r <= '0;
                  changed_r <= 1'b1;
                  mode_r <= M_THROB; step_r <= PresetThrobStep;
                  fading_r <= 1'b1; accel_r <= 1'b1;
                  period_r <= pre_period_r;
                end
                CMD_RSSI: avg_r <= (avg_r >> 2) * 8'd3 + sample;
                default: ;
              endcase
            end
          end
          ST_FILL, ST_ANIM: begin
            lag_v_r <= 1'b1;
            lag_r <= IdxW'(cnt_r - 1'b1);
            lag_last_r <= (cnt_r == CntW'(LedCount));
            idx_r <= idx_r + 1'b1;
            cnt_r <= cnt_r + 1'b1;
          end
          ST_DRAIN: lag_v_r <= 1'b0;
          default: ;
        endcase
        if (lag_v_r && !fill_on_r) begin
          out_valid <= 1'b1;
          out_pixel_index <= 4'(lag_r);
          out_green_out <= new_pix[23:16];
          out_red_out <= new_pix[15:8];
          out_blue_out <= new_pix[7:0];
          out_frame_last <= lag_last_r;
          out_anim_period <= period_r;
          if (mode_r == M_THROB && dec_change) changed_r <= 1'b1;
        end
        if (state_r == ST_DRAIN && !fill_on_r) begin
          unique case (mode_r)
            M_FLASH: flash_r <= !flash_r;
            M_THROB: if (!(changed_r || (lag_v_r && dec_change))) fading_r <= !fading_r;
            M_ONESHOT: pulse_r <= 1'b0;
            default: ;
          endcase
        end
      end
    end
  end

  // capture LED 0 for the rotate wrap
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) first_r <= frame_rd;
  end

endmodule

// ===== sv/lsae_checker.sv =====
// Port checker for the LED string animation engine, bound to the top level.
module lsae_checker
  import lsae_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_frame_last,
  input logic [3:0] out_pixel_index
);

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |=> out_valid && out_pixel_index == $past(out_pixel_index) + 4'd1)
    else $error("pixel index skipped");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_pixel_index == 4'(LedCount - 1))
    else $error("frame_last misplaced");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |-> busy)
    else $error("result while idle");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_pixel_index == 4'd0)
    else $error("frame does not start at LED 0");

endmodule

bind led_string_animation_engine_top lsae_checker u_lsae_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_frame_last(out_frame_last), .out_pixel_index(out_pixel_index)
);
